@@ rtl/portal_graph_depth_limited_walk_assert.svh @@
// Assertion macros for the portal walker
`ifndef PORTAL_GRAPH_DEPTH_LIMITED_WALK_ASSERT_SVH
`define PORTAL_GRAPH_DEPTH_LIMITED_WALK_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define PGDLW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PGDLW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pgdlw_pkg.sv @@
package pgdlw_pkg;

    // Field widths fixed by the interface
    localparam int SEC_W  = 6;
    localparam int SIDE_W = 6;
    localparam int DEP_W  = 4;
    localparam int SCNT_W = 7;
    localparam int CIDX_W = 2;
    localparam int CDAT_W = 7;

    // Request opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_WALK  = 1'b1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_MAX_DEPTH    = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SECTOR_COUNT = 2'd1;

    localparam logic [DEP_W-1:0] MAX_DEPTH_RESET = 4'd10;

    // One portal table entry
    typedef struct packed {
        logic             portal;
        logic [SEC_W-1:0] target;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VCLR,
        ST_LOOKUP,
        ST_ENTER,
        ST_LOOP,
        ST_READ,
        ST_FINISH
    } t_state;

endpackage

@@ rtl/portal_graph_depth_limited_walk.sv @@
// Table write request: accepted while idle, no result.
// Walk request: a pass clears the visited marks, a lookup fetches the start sector's mark, then
// each side scan is a table read followed by a check, and each portal found adds an enter step;
// result stalls can hold the walk, and only one walk runs at a time.
// Reset: a clearing pass writes walls over all SECTORS*SIDES table entries;
// requests stall meanwhile, configuration is taken.
module portal_graph_depth_limited_walk #(
    parameter int SECTORS     = 64,
    parameter int SIDES       = 64,
    parameter int STACK_DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic [pgdlw_pkg::SEC_W-1:0] i_sector,
    input  logic [pgdlw_pkg::SIDE_W-1:0] i_side,
    input  logic                        i_is_portal,
    input  logic [pgdlw_pkg::SEC_W-1:0] i_target,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [pgdlw_pkg::SEC_W-1:0] o_visited_sector,
    output logic [pgdlw_pkg::DEP_W-1:0] o_hop_depth,
    output logic                        o_visible,
    output logic                        o_last,
    // configuration channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pgdlw_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [pgdlw_pkg::CDAT_W-1:0] i_cfg_data
);
    import pgdlw_pkg::*;

`include "portal_graph_depth_limited_walk_assert.svh"

    localparam int DEPTH = SECTORS * SIDES;
    localparam int AW    = $clog2(DEPTH);
    localparam int SIW   = $clog2(SECTORS);
    localparam int SDW   = $clog2(SIDES + 1);
    localparam int SPW   = $clog2(STACK_DEPTH + 1);
    localparam int STW   = $clog2(STACK_DEPTH);

    // Registers
    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr_addr;
    logic [DEP_W-1:0]    r_max_depth;
    logic [SCNT_W-1:0]   r_sector_count;
    logic [SEC_W-1:0]    r_stk_sec  [STACK_DEPTH];
    logic [SDW-1:0]      r_stk_side [STACK_DEPTH];
    logic [SPW-1:0]      r_sp;
    logic                r_pend_valid;
    logic [SEC_W-1:0]    r_pend_sec;
    logic [DEP_W-1:0]    r_pend_depth;
    logic [SEC_W-1:0]    r_cand_sec;
    logic [DEP_W-1:0]    r_cand_depth;
    t_entry              r_rd_data;
    logic                r_vis_rd;
    logic                r_out_valid;
    logic [SEC_W-1:0]    r_out_sec;
    logic [DEP_W-1:0]    r_out_depth;
    logic                r_out_vis;
    logic                r_out_last;

    // Portal table and visited marks
    t_entry              r_mem [DEPTH];
    logic                r_vis_mem [SECTORS];

    // Control
    logic                w_in_acc;
    logic                w_out_free;
    logic                w_can_enter;
    logic [SIW-1:0]      w_cand_idx;
    logic [STW-1:0]      w_top;
    logic [STW-1:0]      w_push_idx;
    logic [SPW-1:0]      w_top_depth;
    logic                w_mem_we;
    logic [AW-1:0]       w_mem_wa;
    t_entry              w_mem_wd;
    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    logic                w_vis_we;
    logic [SIW-1:0]      w_vis_wa;
    logic                w_vis_wd;
    logic                w_vis_re;
    logic [SIW-1:0]      w_vis_ra;
    logic                w_walk_start;
    logic                w_push;
    logic                w_pop;
    logic                w_adv;
    logic                w_load_rd;
    logic                w_emit;
    logic [SEC_W-1:0]    w_emit_sec;
    logic [DEP_W-1:0]    w_emit_depth;
    logic                w_emit_vis;
    logic                w_emit_last;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_cand_idx  = SIW'(r_cand_sec);
    assign w_top       = STW'(r_sp - SPW'(1));
    assign w_push_idx  = STW'(r_sp);
    assign w_top_depth = r_sp - SPW'(1);
    assign w_rd_addr   = AW'(32'(r_stk_sec[w_top]) * SIDES + 32'(r_stk_side[w_top]));

    // Candidate may be entered: in range, unvisited, room on the stack
    assign w_can_enter = ({1'b0, r_cand_sec} < r_sector_count)
                      && (32'(r_cand_sec) < SECTORS)
                      && !r_vis_rd
                      && (32'(r_sp) < STACK_DEPTH);

    // Next state and control decode
    always_comb begin
        n_state      = r_state;
        w_mem_we     = 1'b0;
        w_mem_wa     = r_clr_addr;
        w_mem_wd     = '0;
        w_rd_en      = 1'b0;
        w_vis_we     = 1'b0;
        w_vis_wa     = SIW'(r_clr_addr);
        w_vis_wd     = 1'b0;
        w_vis_re     = 1'b0;
        w_vis_ra     = w_cand_idx;
        w_walk_start = 1'b0;
        w_push       = 1'b0;
        w_pop        = 1'b0;
        w_adv        = 1'b0;
        w_load_rd    = 1'b0;
        w_emit       = 1'b0;
        w_emit_sec   = r_pend_sec;
        w_emit_depth = r_pend_depth;
        w_emit_vis   = 1'b1;
        w_emit_last  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_mem_we = 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_op == OP_WALK) begin
                        w_walk_start = 1'b1;
                        n_state      = ST_VCLR;
                    end else if ((32'(i_sector) < SECTORS) && (32'(i_side) < SIDES)) begin
                        w_mem_we = 1'b1;
                        w_mem_wa = AW'(32'(i_sector) * SIDES + 32'(i_side));
                        w_mem_wd = i_is_portal ? t_entry'{1'b1, i_target} : '0;
                    end
                end
            end
            // Clear one visited mark per cycle
            ST_VCLR: begin
                w_vis_we = 1'b1;
                if (r_clr_addr == AW'(SECTORS - 1)) begin
                    n_state = ST_LOOKUP;
                end
            end
            // Fetch the start sector's mark
            ST_LOOKUP: begin
                w_vis_re = 1'b1;
                n_state  = ST_ENTER;
            end
            ST_ENTER: begin
                if (!w_can_enter) begin
                    n_state = ST_LOOP;
                end else if (!r_pend_valid || w_out_free) begin
                    w_emit   = r_pend_valid;
                    w_push   = 1'b1;
                    w_vis_we = 1'b1;
                    w_vis_wa = w_cand_idx;
                    w_vis_wd = 1'b1;
                    n_state  = ST_LOOP;
                end
            end
            ST_LOOP: begin
                if (r_sp == '0) begin
                    n_state = ST_FINISH;
                end else if ((32'(w_top_depth) >= 32'(r_max_depth))
                          || (32'(r_stk_side[w_top]) >= SIDES)) begin
                    w_pop = 1'b1;
                end else begin
                    w_rd_en = 1'b1;
                    w_adv   = 1'b1;
                    n_state = ST_READ;
                end
            end
            // Portal found: fetch the target's mark along with the candidate
            ST_READ: begin
                if (r_rd_data.portal) begin
                    w_load_rd = 1'b1;
                    w_vis_re  = 1'b1;
                    w_vis_ra  = SIW'(r_rd_data.target);
                    n_state   = ST_ENTER;
                end else begin
                    n_state = ST_LOOP;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    w_emit       = 1'b1;
                    w_emit_last  = 1'b1;
                    w_emit_vis   = r_pend_valid;
                    w_emit_sec   = r_pend_valid ? r_pend_sec : '0;
                    w_emit_depth = r_pend_valid ? r_pend_depth : '0;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance the clearing sweeps, rewind when one ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if ((r_state == ST_CLEAR) || (r_state == ST_VCLR)) begin
            if (n_state != r_state) begin
                r_clr_addr <= '0;
            end else begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // Portal table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= w_mem_wd;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Visited marks: one write port, one registered read port; a mark is set
    // before the next lookup reads the marks, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (w_vis_we) begin
            r_vis_mem[w_vis_wa] <= w_vis_wd;
        end
        if (w_vis_re) begin
            r_vis_rd <= r_vis_mem[w_vis_ra];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_depth    <= MAX_DEPTH_RESET;
            r_sector_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAX_DEPTH:    r_max_depth    <= i_cfg_data[DEP_W-1:0];
                CFG_SECTOR_COUNT: r_sector_count <= i_cfg_data[SCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Walk control: stack pointer, held result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp         <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (w_walk_start) begin
                r_sp         <= '0;
                r_pend_valid <= 1'b0;
            end else if (w_push) begin
                r_sp         <= r_sp + SPW'(1);
                r_pend_valid <= 1'b1;
            end else if (w_pop) begin
                r_sp <= r_sp - SPW'(1);
            end else if (w_emit && w_emit_last) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // Walk payload: frames, candidate, held result
    always_ff @(posedge i_clk) begin
        if (w_walk_start) begin
            r_cand_sec   <= i_sector;
            r_cand_depth <= '0;
        end else if (w_load_rd) begin
            r_cand_sec   <= r_rd_data.target;
            r_cand_depth <= DEP_W'(r_sp);
        end
        if (w_push) begin
            r_stk_sec[w_push_idx]  <= r_cand_sec;
            r_stk_side[w_push_idx] <= '0;
            r_pend_sec             <= r_cand_sec;
            r_pend_depth           <= r_cand_depth;
        end else if (w_adv) begin
            r_stk_side[w_top] <= r_stk_side[w_top] + SDW'(1);
        end
    end

    // Output register: drop when taken, load on emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_sec   <= w_emit_sec;
            r_out_depth <= w_emit_depth;
            r_out_vis   <= w_emit_vis;
            r_out_last  <= w_emit_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_visited_sector = r_out_sec;
    assign o_hop_depth      = r_out_depth;
    assign o_visible        = r_out_vis;
    assign o_last           = r_out_last;

    // Checks
    `PGDLW_ASSERT_NOW(a_push_unvisited, i_clk, i_rst_n, w_push, !r_vis_rd, "push into visited sector")
    `PGDLW_ASSERT_NOW(a_emit_room, i_clk, i_rst_n, w_emit, w_out_free, "result emitted over a held result")
    `PGDLW_ASSERT_NOW(a_read_frame, i_clk, i_rst_n, r_state == ST_READ, r_sp != '0, "table read with empty stack")
    `PGDLW_ASSERT_NEXT(a_walk_init, i_clk, i_rst_n, w_in_acc && (i_op == OP_WALK), (r_state == ST_VCLR) && (r_sp == '0) && !r_pend_valid, "walk start not initialised")

endmodule
